// ===== hw/rtl/rotation_matrix_orthonormalizer_assert.svh =====
`ifndef ROTATION_MATRIX_ORTHONORMALIZER_ASSERT_SVH
`define ROTATION_MATRIX_ORTHONORMALIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define RMO_ASSERT_IMPL(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("rmo implication check failed");
`define RMO_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("rmo next-cycle check failed");
`else
`define RMO_ASSERT_IMPL(name, clk, rst_n, pre, post)
`define RMO_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif

`endif

// ===== hw/rtl/rmo_pkg.sv =====
package rmo_pkg;

	localparam int DIM = 3;
	localparam int R_W = 32;
	localparam int S_W = 64;
	localparam int DEV_W = 63;
	localparam int OP_A_W = 34;
	localparam int LO_W = 30;
	localparam int TERM_W = 68;
	localparam int CNT_W = 4;

	localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};
	localparam logic signed [S_W-1:0] ONE_Q58 = 64'sd1 <<< 58;

	localparam logic [1:0] REG_FIX = 2'd0;
	localparam logic [1:0] REG_STOP = 2'd1;
	localparam logic [1:0] REG_MAXIT = 2'd2;

	localparam logic [CNT_W-1:0] MAT_ISSUES = 4'd9;
	localparam logic [CNT_W-1:0] MAT_END = 4'd10;
	localparam logic [CNT_W-1:0] DEV_ISSUES = 4'd3;
	localparam logic [CNT_W-1:0] DEV_END = 4'd5;

	typedef enum logic [1:0] {
		OP_GRAM,
		OP_DEV,
		OP_ITER
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GRAM,
		ST_DEV,
		ST_ITER,
		ST_COPY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [OP_A_W-1:0] a;
		logic signed [OP_A_W-1:0] b;
		logic [LO_W-1:0] lo;
	} lane_in_t;

	typedef logic signed [TERM_W-1:0] term_t;

	typedef struct packed {
		logic valid;
		op_t op;
		logic [1:0] i;
		logic [1:0] j;
	} tag_t;

	typedef struct packed {
		logic valid;
		op_t op;
		logic [1:0] i;
		logic [1:0] j;
		logic signed [S_W-1:0] s_val;
		logic [DEV_W-1:0] acc;
		logic signed [R_W-1:0] r_new;
	} wr_t;

endpackage

// ===== hw/rtl/rotation_matrix_orthonormalizer.sv =====
// Each correction iteration (up to 7, set by max_iterations) adds to the time from input
// request accept to result valid.
// Requests are taken one at a time: the next is accepted only once the last result is finished.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low, asynchronous) returns to idle, empties the output register,
// clears the running maximum and loads the register defaults.
module rotation_matrix_orthonormalizer (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// in_r00 .. in_r22, 32 bits each, row-major from the lowest bit up.
	input logic [287:0] s_axis_tdata,
	// batch_start.
	input logic s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// out_r00 .. out_r22 (32 bits each), deviation_before (63), batch_max_deviation (63),
	// two zero bits.
	output logic [415:0] m_axis_tdata,
	// was_fixed.
	output logic m_axis_tuser,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [62:0] cfg_data
);
	import rmo_pkg::*;

	`include "rotation_matrix_orthonormalizer_assert.svh"

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] ci_q, cj_q;
	logic first_q, fixed_q;
	logic [2:0] it_cnt_q;
	logic [3:0] it_next;
	logic [DEV_W-1:0] fix_thr_q, stop_thr_q, runmax_q, acc_q, dev0_q;
	logic [2:0] max_iter_q;
	logic signed [R_W-1:0] r_q [DIM][DIM];
	logic signed [R_W-1:0] nr_q [DIM][DIM];
	logic signed [S_W-1:0] s_q [DIM][DIM];
	logic signed [R_W-1:0] out_r_q [DIM][DIM];
	logic [DEV_W-1:0] out_dev_q, out_max_q;
	logic out_fixed_q;
	logic m_valid_q;
	logic issue;
	op_t op;
	lane_in_t lane_in [DIM];
	term_t terms [DIM];
	tag_t tag;
	wr_t wr;
	logic out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser = out_fixed_q;
	assign out_free = !m_valid_q || m_axis_tready;
	assign it_next = {1'b0, it_cnt_q} + 4'd1;

	always_comb begin
		logic signed [S_W-1:0] m;
		logic signed [S_W:0] mq;
		m = '0;
		mq = '0;
		issue = 1'b0;
		op = OP_GRAM;
		for (int k = 0; k < DIM; k++) begin
			lane_in[k] = '0;
		end
		case (state_q)
			ST_GRAM: begin
				issue = (cnt_q < MAT_ISSUES);
				op = OP_GRAM;
				for (int k = 0; k < DIM; k++) begin
					lane_in[k].a = OP_A_W'(r_q[ci_q][k]);
					lane_in[k].b = OP_A_W'(r_q[cj_q][k]);
				end
			end
			ST_DEV: begin
				issue = (cnt_q < DEV_ISSUES);
				op = OP_DEV;
				for (int k = 0; k < DIM; k++) begin
					m = s_q[cnt_q[1:0]][k] - ((cnt_q[1:0] == 2'(k)) ? ONE_Q58 : '0);
					mq = (S_W+1)'(m) + ((S_W+1)'(1) <<< 29);
					lane_in[k].a = mq[63:30];
					lane_in[k].b = mq[63:30];
				end
			end
			ST_ITER: begin
				issue = (cnt_q < MAT_ISSUES);
				op = OP_ITER;
				for (int k = 0; k < DIM; k++) begin
					lane_in[k].a = s_q[ci_q][k][63:30];
					lane_in[k].lo = s_q[ci_q][k][29:0];
					lane_in[k].b = OP_A_W'(r_q[k][cj_q]);
				end
			end
			default: begin
				issue = 1'b0;
			end
		endcase
		tag.valid = issue;
		tag.op = op;
		tag.i = (state_q == ST_DEV) ? cnt_q[1:0] : ci_q;
		tag.j = cj_q;
	end

	for (genvar k = 0; k < DIM; k++) begin : g_lane
		rmo_lane u_lane (
			.clk (clk),
			.op (op),
			.din (lane_in[k]),
			.term (terms[k])
		);
	end

	rmo_merge u_merge (
		.clk (clk),
		.arst_n (arst_n),
		.tag (tag),
		.term0 (terms[0]),
		.term1 (terms[1]),
		.term2 (terms[2]),
		.acc_in (acc_q),
		.r_ij (r_q[wr.i][wr.j]),
		.wr (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_GRAM;
				end
			end
			ST_GRAM: begin
				if (cnt_q == MAT_END) begin
					state_d = ST_DEV;
				end
			end
			ST_DEV: begin
				if (cnt_q == DEV_END) begin
					if (first_q) begin
						state_d = (acc_q > fix_thr_q && max_iter_q != 3'd0) ? ST_ITER : ST_DONE;
					end else if (acc_q < stop_thr_q || it_next == {1'b0, max_iter_q}) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_ITER;
					end
				end
			end
			ST_ITER: begin
				if (cnt_q == MAT_END) begin
					state_d = ST_COPY;
				end
			end
			ST_COPY: begin
				state_d = ST_GRAM;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ci_q <= '0;
			cj_q <= '0;
			first_q <= 1'b0;
			fixed_q <= 1'b0;
			it_cnt_q <= '0;
			runmax_q <= '0;
			m_valid_q <= 1'b0;
			fix_thr_q <= '0;
			stop_thr_q <= 63'd1;
			max_iter_q <= 3'd3;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_FIX: fix_thr_q <= cfg_data;
					REG_STOP: stop_thr_q <= cfg_data;
					REG_MAXIT: max_iter_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (state_d != state_q) begin
				cnt_q <= '0;
				ci_q <= '0;
				cj_q <= '0;
			end else begin
				cnt_q <= cnt_q + 4'd1;
				if (issue && state_q != ST_DEV) begin
					if (cj_q == 2'd2) begin
						cj_q <= '0;
						ci_q <= ci_q + 2'd1;
					end else begin
						cj_q <= cj_q + 2'd1;
					end
				end
			end
			if (state_q == ST_IDLE && s_axis_tvalid) begin
				first_q <= 1'b1;
				it_cnt_q <= '0;
				if (s_axis_tuser) begin
					runmax_q <= '0;
				end
			end
			if (state_q == ST_DEV && cnt_q == DEV_END) begin
				if (first_q) begin
					first_q <= 1'b0;
					fixed_q <= (acc_q > fix_thr_q);
					if (acc_q > runmax_q) begin
						runmax_q <= acc_q;
					end
				end else begin
					it_cnt_q <= it_next[2:0];
				end
			end
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			for (int i = 0; i < DIM; i++) begin
				for (int j = 0; j < DIM; j++) begin
					r_q[i][j] <= s_axis_tdata[(i*DIM+j)*R_W +: R_W];
				end
			end
		end else if (state_q == ST_COPY) begin
			r_q <= nr_q;
		end
		if (wr.valid && wr.op == OP_GRAM) begin
			s_q[wr.i][wr.j] <= wr.s_val;
		end
		if (wr.valid && wr.op == OP_ITER) begin
			nr_q[wr.i][wr.j] <= wr.r_new;
		end
		if (state_d == ST_DEV && state_q != ST_DEV) begin
			acc_q <= '0;
		end else if (wr.valid && wr.op == OP_DEV) begin
			acc_q <= wr.acc;
		end
		if (state_q == ST_DEV && cnt_q == DEV_END && first_q) begin
			dev0_q <= acc_q;
		end
		if (state_q == ST_DONE && out_free) begin
			out_r_q <= r_q;
			out_dev_q <= dev0_q;
			out_max_q <= runmax_q;
			out_fixed_q <= fixed_q;
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < DIM; i++) begin
			for (int j = 0; j < DIM; j++) begin
				m_axis_tdata[(i*DIM+j)*R_W +: R_W] = out_r_q[i][j];
			end
		end
		m_axis_tdata[350:288] = out_dev_q;
		m_axis_tdata[413:351] = out_max_q;
	end

	`RMO_ASSERT_IMPL(a_iter_only_when_fixed, clk, arst_n, state_q == ST_ITER, fixed_q)
	`RMO_ASSERT_IMPL(a_iter_within_limit, clk, arst_n, state_q == ST_ITER, it_cnt_q < max_iter_q)
	`RMO_ASSERT_IMPL(a_max_covers_dev, clk, arst_n, m_axis_tvalid, out_max_q >= out_dev_q)
	`RMO_ASSERT_NEXT(a_accept_starts_gram, clk, arst_n, s_axis_tvalid && s_axis_tready, state_q == ST_GRAM)

endmodule

// ===== hw/rtl/rmo_lane.sv =====
module rmo_lane (
	input logic clk,
	input rmo_pkg::op_t op,
	input rmo_pkg::lane_in_t din,
	output rmo_pkg::term_t term
);
	import rmo_pkg::*;

	logic signed [2*OP_A_W-1:0] m1_s1;
	logic signed [LO_W+OP_A_W:0] m2_s1;
	op_t op_s1;

	always_ff @(posedge clk) begin
		m1_s1 <= din.a * din.b;
		m2_s1 <= $signed({1'b0, din.lo}) * din.b;
		op_s1 <= op;
	end

	always_ff @(posedge clk) begin
		case (op_s1)
			OP_GRAM: term <= m1_s1 >>> 2;
			OP_ITER: term <= (m1_s1 + (TERM_W'(m2_s1) >>> LO_W)) >>> 2;
			OP_DEV: term <= m1_s1;
			default: term <= '0;
		endcase
	end

endmodule

// ===== hw/rtl/rmo_merge.sv =====
module rmo_merge (
	input logic clk,
	input logic arst_n,
	input rmo_pkg::tag_t tag,
	input rmo_pkg::term_t term0,
	input rmo_pkg::term_t term1,
	input rmo_pkg::term_t term2,
	input logic [rmo_pkg::DEV_W-1:0] acc_in,
	input logic signed [rmo_pkg::R_W-1:0] r_ij,
	output rmo_pkg::wr_t wr
);
	import rmo_pkg::*;

	tag_t tag_s1;
	tag_t tag_s2;
	logic signed [TERM_W+1:0] sum;
	logic signed [TERM_W+2:0] x;
	logic signed [TERM_W+2:0] y;
	logic [TERM_W+2:0] acc_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
		end
	end

	always_comb begin
		sum = (TERM_W+2)'(term0) + (TERM_W+2)'(term1) + (TERM_W+2)'(term2);
		x = (((TERM_W+3)'(r_ij) * 3) <<< 26) - (TERM_W+3)'(sum);
		y = (x + ((TERM_W+3)'(1) <<< 26)) >>> 27;
		acc_sum = (TERM_W+3)'(acc_in) + (TERM_W+3)'($unsigned(sum));
		wr.valid = tag_s2.valid;
		wr.op = tag_s2.op;
		wr.i = tag_s2.i;
		wr.j = tag_s2.j;
		wr.s_val = sum[S_W-1:0];
		if (acc_sum > (TERM_W+3)'(DEV_MAX)) begin
			wr.acc = DEV_MAX;
		end else begin
			wr.acc = acc_sum[DEV_W-1:0];
		end
		if (y > (TERM_W+3)'(32'sh7FFF_FFFF)) begin
			wr.r_new = 32'sh7FFF_FFFF;
		end else if (y < -(TERM_W+3)'(33'sh0_8000_0000)) begin
			wr.r_new = 32'sh8000_0000;
		end else begin
			wr.r_new = y[R_W-1:0];
		end
	end

endmodule
